[rtl/core/hst_pkg.sv]
// Shared types and constants for the two-sided hit station trigger.
package hst_pkg;

  localparam int NUM_MODULES_DEF  = 4096;
  localparam int NUM_STRIPS_DEF   = 4096;
  localparam int NUM_STATIONS_DEF = 16;

  localparam int OP_W      = 2;
  localparam int ELEM_W    = 12;
  localparam int CHAN_W    = 11;
  localparam int STATION_W = 4;
  localparam int MIN_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int EPOCH_W   = 8;
  localparam int CODE_W    = 2;
  localparam int ENTRY_W   = EPOCH_W + CODE_W;

  localparam logic [OP_W-1:0] OP_STS = 2'd0;
  localparam logic [OP_W-1:0] OP_TOF = 2'd1;
  localparam logic [OP_W-1:0] OP_EOE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_STS_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOF_MIN = 2'd1;

  localparam logic [CODE_W-1:0] SIDE_NONE = 2'd0;
  localparam logic [CODE_W-1:0] SIDE_ZERO = 2'd1;
  localparam logic [CODE_W-1:0] SIDE_ONE  = 2'd2;

  localparam logic [MIN_W-1:0] COUNT_SAT = 5'd31;

  typedef enum logic [1:0] {
    KIND_STS = 2'd0,
    KIND_TOF = 2'd1,
    KIND_EOE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [ELEM_W-1:0]    elem;
    logic                 side;
    logic [STATION_W-1:0] station;
  } cmd_t;

endpackage

[rtl/core/hst_if.sv]
// Channel interfaces: hit input, result output and register write.
interface hst_in_if;
  import hst_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [ELEM_W-1:0]    element_id;
  logic [CHAN_W-1:0]    channel;
  logic                 strip_end;
  logic [STATION_W-1:0] station_id;
  modport source (output valid, op, element_id, channel, strip_end, station_id, input ready);
  modport sink (input valid, op, element_id, channel, strip_end, station_id, output ready);
endinterface

interface hst_out_if;
  import hst_pkg::*;
  logic             valid;
  logic             ready;
  logic             accepted;
  logic [MIN_W-1:0] sts_stations_found;
  logic [MIN_W-1:0] tof_stations_found;
  modport source (output valid, accepted, sts_stations_found, tof_stations_found,
                  input ready);
  modport sink (input valid, accepted, sts_stations_found, tof_stations_found,
                output ready);
endinterface

interface hst_cfg_if;
  import hst_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MIN_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/hst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/hst_front.sv]
// Front end: decode requests, drop those with no effect, queue the rest.
module hst_front import hst_pkg::*; #(
  parameter int NUM_MODULES = NUM_MODULES_DEF,
  parameter int NUM_STRIPS  = NUM_STRIPS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  hst_in_if.sink    hit_in,
  output cmd_t      head,
  output logic      head_valid,
  input  logic      pop
);
  cmd_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  cmd_t       cmd;
  logic       keep;
  logic       push;

  always_comb begin
    cmd.elem    = hit_in.element_id;
    cmd.side    = (hit_in.op == OP_TOF) ? hit_in.strip_end : hit_in.channel[CHAN_W-1];
    cmd.station = hit_in.station_id;
    cmd.kind    = KIND_EOE;
    keep        = 1'b0;
    case (hit_in.op)
      OP_STS: begin
        cmd.kind = KIND_STS;
        keep     = 32'(hit_in.element_id) < 32'(NUM_MODULES);
      end
      OP_TOF: begin
        cmd.kind = KIND_TOF;
        keep     = 32'(hit_in.element_id) < 32'(NUM_STRIPS);
      end
      OP_EOE: begin
        cmd.kind = KIND_EOE;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign hit_in.ready = (count != 2'd2);
  assign push         = hit_in.valid && hit_in.ready && keep;
  assign head         = q[rptr];
  assign head_valid   = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cmd;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

[rtl/core/hst_back.sv]
// Back end: side tables, station marks, event decision and result register.
module hst_back import hst_pkg::*; #(
  parameter int NUM_MODULES  = NUM_MODULES_DEF,
  parameter int NUM_STRIPS   = NUM_STRIPS_DEF,
  parameter int NUM_STATIONS = NUM_STATIONS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             head,
  input  logic             head_valid,
  output logic             pop,
  input  logic [MIN_W-1:0] sts_min,
  input  logic [MIN_W-1:0] tof_min,
  hst_out_if.source        res_out
);
  localparam int MOD_AW = $clog2(NUM_MODULES);
  localparam int STR_AW = $clog2(NUM_STRIPS);
  localparam int CLR_D  = (NUM_MODULES > NUM_STRIPS) ? NUM_MODULES : NUM_STRIPS;
  localparam int CLR_W  = $clog2(CLR_D);
  localparam int CNT_W  = $clog2(NUM_STATIONS + 1);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_READ  = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [CLR_W-1:0]    clr_cnt;
  logic [EPOCH_W-1:0]  epoch;
  cmd_t                cur;
  logic [NUM_STATIONS-1:0] sts_marks, tof_marks;

  logic                mod_we, str_we;
  logic [MOD_AW-1:0]   mod_waddr, mod_raddr;
  logic [STR_AW-1:0]   str_waddr, str_raddr;
  logic [ENTRY_W-1:0]  wdata, mod_rdata, str_rdata, rd;
  logic [31:0]         head_ext, cur_ext, clr_ext;

  logic [CNT_W-1:0]    sts_cnt, tof_cnt;
  logic [MIN_W-1:0]    sts_sat, tof_sat;
  logic                ok, eoe_go, seen, mark;
  logic [CODE_W-1:0]   code;
  logic [NUM_STATIONS-1:0] st_bit;
  logic                res_valid_q;

  assign head_ext = 32'(head.elem);
  assign cur_ext  = 32'(cur.elem);
  assign clr_ext  = 32'(clr_cnt);

  hst_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_MODULES)) u_mod_ram (
    .clk, .we(mod_we), .waddr(mod_waddr), .wdata, .raddr(mod_raddr), .rdata(mod_rdata)
  );
  hst_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_STRIPS)) u_str_ram (
    .clk, .we(str_we), .waddr(str_waddr), .wdata, .raddr(str_raddr), .rdata(str_rdata)
  );

  assign mod_raddr = head_ext[MOD_AW-1:0];
  assign str_raddr = head_ext[STR_AW-1:0];

  always_comb begin
    sts_cnt = '0;
    tof_cnt = '0;
    for (int i = 0; i < NUM_STATIONS; i++) begin
      sts_cnt = sts_cnt + CNT_W'(sts_marks[i]);
      tof_cnt = tof_cnt + CNT_W'(tof_marks[i]);
    end
    sts_sat = (32'(sts_cnt) > 32'(COUNT_SAT)) ? COUNT_SAT : MIN_W'(sts_cnt);
    tof_sat = (32'(tof_cnt) > 32'(COUNT_SAT)) ? COUNT_SAT : MIN_W'(tof_cnt);
    ok = 1'b1;
    if (sts_min != '0 && 32'(sts_cnt) < 32'(sts_min)) ok = 1'b0;
    if (tof_min != '0 && 32'(tof_cnt) < 32'(tof_min)) ok = 1'b0;
  end

  always_comb begin
    st_bit = '0;
    for (int i = 0; i < NUM_STATIONS; i++) begin
      if (32'(cur.station) == i) st_bit[i] = 1'b1;
    end
  end

  // Entries tagged with an older epoch read as not seen.
  assign rd     = (cur.kind == KIND_TOF) ? str_rdata : mod_rdata;
  assign seen   = (rd[CODE_W-1:0] != SIDE_NONE) && (rd[ENTRY_W-1:CODE_W] == epoch);
  assign code   = cur.side ? SIDE_ONE : SIDE_ZERO;
  assign mark   = (state == S_READ) && seen && (rd[CODE_W-1:0] != code);
  assign eoe_go = (state == S_IDLE) && head_valid && (head.kind == KIND_EOE) &&
                  (!res_out.valid || res_out.ready);

  always_comb begin
    pop        = 1'b0;
    state_next = state;
    mod_we     = 1'b0;
    str_we     = 1'b0;
    mod_waddr  = cur_ext[MOD_AW-1:0];
    str_waddr  = cur_ext[STR_AW-1:0];
    wdata      = {epoch, code};
    case (state)
      S_CLEAR: begin
        mod_waddr  = clr_ext[MOD_AW-1:0];
        str_waddr  = clr_ext[STR_AW-1:0];
        wdata      = '0;
        mod_we     = clr_ext < 32'(NUM_MODULES);
        str_we     = clr_ext < 32'(NUM_STRIPS);
        if (clr_ext == 32'(CLR_D - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (head_valid && head.kind != KIND_EOE) begin
          pop        = 1'b1;
          state_next = S_READ;
        end else if (eoe_go) begin
          pop = 1'b1;
          if (epoch == {EPOCH_W{1'b1}}) state_next = S_CLEAR;
        end
      end
      S_READ: begin
        mod_we     = !seen && (cur.kind == KIND_STS);
        str_we     = !seen && (cur.kind == KIND_TOF);
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign res_out.valid = res_valid_q;

  always_ff @(posedge clk) begin
    if (state == S_IDLE && head_valid && head.kind != KIND_EOE) begin
      cur <= head;
    end
    if (eoe_go) begin
      res_out.accepted           <= ok;
      res_out.sts_stations_found <= sts_sat;
      res_out.tof_stations_found <= tof_sat;
    end
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      epoch       <= '0;
      sts_marks   <= '0;
      tof_marks   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      else clr_cnt <= '0;
      if (eoe_go) begin
        epoch     <= epoch + 1'b1;
        sts_marks <= '0;
        tof_marks <= '0;
      end else if (mark) begin
        if (cur.kind == KIND_TOF) tof_marks <= tof_marks | st_bit;
        else sts_marks <= sts_marks | st_bit;
      end
      if (eoe_go) res_valid_q <= 1'b1;
      else if (res_out.ready) res_valid_q <= 1'b0;
    end
  end
endmodule

[rtl/core/two_sided_hit_station_trigger.sv]
// Top level of the two-sided hit station trigger.
// In the table unit a hit is a RAM read, then a compare and write back, and the unit
// takes no new request until the last hit is done; an end-of-event request is taken
// once the result register is free, and hits with no effect (element out of range,
// unused op) are dropped at the input and cost nothing there. A two-entry queue parts the
// input from the table unit. Tables are cleared by epoch tagging; after reset, and after
// every 256 events when the epoch wraps, a clearing pass over max(NUM_MODULES, NUM_STRIPS)
// entries runs (4096 by default) during which queued requests wait; register writes are
// taken at any time.
module two_sided_hit_station_trigger import hst_pkg::*; #(
  parameter int NUM_MODULES  = NUM_MODULES_DEF,
  parameter int NUM_STRIPS   = NUM_STRIPS_DEF,
  parameter int NUM_STATIONS = NUM_STATIONS_DEF
) (
  input logic       clk,
  input logic       rst,
  hst_in_if.sink    hit_in,
  hst_out_if.source res_out,
  hst_cfg_if.sink   cfg
);
  cmd_t             head;
  logic             head_valid;
  logic             pop;
  logic [MIN_W-1:0] sts_min;
  logic [MIN_W-1:0] tof_min;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sts_min <= '0;
      tof_min <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_STS_MIN: sts_min <= cfg.data;
        REG_TOF_MIN: tof_min <= cfg.data;
        default: ;
      endcase
    end
  end

  hst_front #(.NUM_MODULES(NUM_MODULES), .NUM_STRIPS(NUM_STRIPS)) u_front (
    .clk, .rst, .hit_in, .head, .head_valid, .pop
  );

  hst_back #(
    .NUM_MODULES(NUM_MODULES), .NUM_STRIPS(NUM_STRIPS), .NUM_STATIONS(NUM_STATIONS)
  ) u_back (
    .clk, .rst, .head, .head_valid, .pop, .sts_min, .tof_min, .res_out
  );
endmodule

[dv/tb_two_sided_hit_station_trigger.sv]
// Self-checking testbench for the two-sided hit station trigger.
module tb_two_sided_hit_station_trigger;
  import hst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [ELEM_W-1:0]    elem;
    logic [CHAN_W-1:0]    chan;
    logic                 strip_end;
    logic [STATION_W-1:0] station;
  } hit_t;

  typedef struct {
    logic             accepted;
    logic [MIN_W-1:0] sts_found;
    logic [MIN_W-1:0] tof_found;
  } verdict_t;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hst_in_if  hit_in ();
  hst_out_if res_out ();
  hst_cfg_if cfg ();

  two_sided_hit_station_trigger u_dut (
    .clk(clk), .rst(rst), .hit_in(hit_in.sink), .res_out(res_out.source), .cfg(cfg.sink)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  logic [CODE_W-1:0] module_side [NUM_MODULES_DEF];
  logic [CODE_W-1:0] strip_side [NUM_STRIPS_DEF];
  logic [NUM_STATIONS_DEF-1:0] sts_marks, tof_marks;
  logic [MIN_W-1:0] sts_min, tof_min;

  hit_t     hit_queue[$];
  verdict_t verdict_queue[$];
  int  errors = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_off = 0;

  function automatic void clear_event_marks();
    foreach (module_side[i]) module_side[i] = SIDE_NONE;
    foreach (strip_side[i]) strip_side[i] = SIDE_NONE;
    sts_marks = '0;
    tof_marks = '0;
  endfunction

  function automatic int popcount16(logic [NUM_STATIONS_DEF-1:0] m);
    int n = 0;
    for (int i = 0; i < NUM_STATIONS_DEF; i++) n += m[i];
    return n;
  endfunction

  function automatic void predict_trigger(hit_t h);
    logic [CODE_W-1:0] code;
    verdict_t v;
    int ns, nt;
    if (h.op == OP_STS) begin
      code = h.chan[CHAN_W-1] ? SIDE_ONE : SIDE_ZERO;
      if (module_side[h.elem] == SIDE_NONE) module_side[h.elem] = code;
      else if (module_side[h.elem] != code) sts_marks[h.station] = 1'b1;
    end else if (h.op == OP_TOF) begin
      code = h.strip_end ? SIDE_ONE : SIDE_ZERO;
      if (strip_side[h.elem] == SIDE_NONE) strip_side[h.elem] = code;
      else if (strip_side[h.elem] != code) tof_marks[h.station] = 1'b1;
    end else if (h.op == OP_EOE) begin
      ns = popcount16(sts_marks);
      nt = popcount16(tof_marks);
      v.accepted = !((sts_min != 0 && ns < sts_min) || (tof_min != 0 && nt < tof_min));
      v.sts_found = MIN_W'(ns);
      v.tof_found = MIN_W'(nt);
      verdict_queue.push_back(v);
      clear_event_marks();
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      hit_in.valid <= 1'b0;
    end else begin
      if (hit_in.valid && hit_in.ready) begin
        predict_trigger(hit_queue.pop_front());
        send_gap = $urandom_range(0, 9) * ($urandom_range(0, 2) == 0);
      end
      if ((!hit_in.valid || hit_in.ready) ) begin
        if (send_gap > 0) begin
          send_gap--;
          hit_in.valid <= 1'b0;
        end else if (hit_queue.size() > 0) begin
          hit_in.valid      <= 1'b1;
          hit_in.op         <= hit_queue[0].op;
          hit_in.element_id <= hit_queue[0].elem;
          hit_in.channel    <= hit_queue[0].chan;
          hit_in.strip_end  <= hit_queue[0].strip_end;
          hit_in.station_id <= hit_queue[0].station;
        end else begin
          hit_in.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst) begin
      res_out.ready <= 1'b0;
    end else begin
      if (res_out.valid && res_out.ready) begin
        if (verdict_queue.size() == 0) begin
          $error("result with no event pending");
          errors++;
        end else begin
          exp_v = verdict_queue.pop_front();
          if (res_out.accepted !== exp_v.accepted) begin
            $error("accepted: expected %0d actual %0d", exp_v.accepted, res_out.accepted);
            errors++;
          end
          if (res_out.sts_stations_found !== exp_v.sts_found) begin
            $error("sts_stations_found: expected %0d actual %0d", exp_v.sts_found,
                   res_out.sts_stations_found);
            errors++;
          end
          if (res_out.tof_stations_found !== exp_v.tof_found) begin
            $error("tof_stations_found: expected %0d actual %0d", exp_v.tof_found,
                   res_out.tof_stations_found);
            errors++;
          end
        end
        recv_gap = $urandom_range(0, 9) * ($urandom_range(0, 2) == 0);
      end
      if (hold_off > 0) begin
        hold_off--;
        res_out.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        res_out.ready <= 1'b0;
      end else begin
        res_out.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MIN_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == REG_STS_MIN) sts_min = value;
    else tof_min = value;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (hit_queue.size() > 0 || hit_in.valid || verdict_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic void add_hit(logic [OP_W-1:0] op, int elem, int chan, int e, int st);
    hit_t h;
    h.op = op;
    h.elem = ELEM_W'(elem);
    h.chan = CHAN_W'(chan);
    h.strip_end = 1'(e);
    h.station = STATION_W'(st);
    hit_queue.push_back(h);
  endfunction

  // random event: STS, TOF and unused-op hits on ten elements near a random base, then an end-of-event
  task automatic add_random_event(int n_hits);
    int base, k, st;
    base = $urandom_range(0, 4095 - 16);
    for (int i = 0; i < n_hits; i++) begin
      k = $urandom_range(0, 9);
      st = $urandom_range(0, 15);
      case ($urandom_range(0, 9))
        0: add_hit(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
        1, 2, 3, 4: add_hit(OP_STS, base + k, $urandom_range(0, 2047), $urandom, st);
        default: add_hit(OP_TOF, base + k, $urandom, $urandom_range(0, 1), st);
      endcase
    end
    add_hit(OP_EOE, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int phase_mins[4][2] = '{'{0, 0}, '{31, 0}, '{3, 2}, '{1, 16}};
    hit_in.valid = 1'b0;
    hit_in.op = OP_EOE;
    hit_in.element_id = '0;
    hit_in.channel = '0;
    hit_in.strip_end = 1'b0;
    hit_in.station_id = '0;
    res_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_STS_MIN;
    cfg.data = '0;
    sts_min = '0;
    tof_min = '0;
    clear_event_marks();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, repeats, all sixteen stations, unused op
    add_hit(OP_EOE, 0, 0, 0, 0);
    add_hit(OP_STS, 0, 0, 0, 0);
    add_hit(OP_STS, 0, 1023, 0, 0);
    add_hit(OP_STS, 0, 1024, 0, 15);
    add_hit(OP_STS, 0, 2047, 1, 3);
    add_hit(OP_STS, 0, 0, 0, 7);
    add_hit(OP_STS, 4095, 2047, 1, 15);
    add_hit(OP_STS, 4095, 0, 0, 15);
    add_hit(OP_TOF, 4095, 2047, 1, 0);
    add_hit(OP_TOF, 4095, 0, 0, 15);
    add_hit(OP_TOF, 0, 0, 0, 9);
    add_hit(OP_TOF, 0, 0, 1, 9);
    add_hit(OP_UNUSED, 4095, 2047, 1, 15);
    add_hit(OP_EOE, 4095, 2047, 1, 15);
    for (int s = 0; s < 16; s++) begin
      add_hit(OP_STS, 100 + s, 5, 0, s);
      add_hit(OP_STS, 100 + s, 1500, 0, s);
    end
    add_hit(OP_EOE, 0, 0, 0, 0);
    wait_drained();

    foreach (phase_mins[p]) begin
      write_reg(REG_STS_MIN, MIN_W'(phase_mins[p][0]));
      write_reg(REG_TOF_MIN, MIN_W'(phase_mins[p][1]));
      if (p == 1) begin
        // stall the receiver while events queue up behind it
        hold_off = 300;
        for (int i = 0; i < 20; i++) add_random_event(4);
      end
      for (int ev = 0; ev < 15; ev++) add_random_event($urandom_range(2, 30));
      wait_drained();
    end
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
